// ===== rtl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants of the life grid generation step block: action
// codes, register indexes, stream widths and the controller interface.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 128;

    localparam int ACT_W       = 2;
    localparam int POS_W       = 7;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 8'd100;

    typedef enum logic [9:0] {
        ST_CLEAR    = 10'b00_0000_0001,
        ST_IDLE     = 10'b00_0000_0010,
        ST_DISPATCH = 10'b00_0000_0100,
        ST_CELL_RD  = 10'b00_0000_1000,
        ST_CELL_UPD = 10'b00_0001_0000,
        ST_ADV_LOAD = 10'b00_0010_0000,
        ST_ADV_CUR  = 10'b00_0100_0000,
        ST_ADV_RD   = 10'b00_1000_0000,
        ST_ADV_WR   = 10'b01_0000_0000,
        ST_DONE     = 10'b10_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        RD_CELL,
        RD_CUR,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_ZERO,
        WR_CELL,
        WR_GEN
    } wr_sel_t;

    typedef struct packed {
        logic    item_load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cur_load;
        logic    adv_step;
        logic    cnt_clr;
        logic    row_inc;
        logic    res_load;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             oor;
        logic             empty;
        logic             last_clear;
        logic             last_gen;
        logic             out_free;
    } sts_t;

endpackage

// ===== rtl/lgs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lgs_ctrl
// Controller state machine: clearing pass after reset, request dispatch,
// single-cell read and write sequences and the row-by-row generation sweep.
// ----------------------------------------------------------------------------
module lgs_ctrl
    import lgs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd.item_load = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.rd_sel    = RD_CELL;
        cmd.wr_en     = 1'b0;
        cmd.wr_sel    = WR_ZERO;
        cmd.cur_load  = 1'b0;
        cmd.adv_step  = 1'b0;
        cmd.cnt_clr   = 1'b0;
        cmd.row_inc   = 1'b0;
        cmd.res_load  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_ZERO;
                cmd.row_inc = 1'b1;
                if (sts.last_clear)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (sts.action) inside
                    ACT_WRITE, ACT_READ:
                    begin
                        state_next = sts.oor ? ST_DONE : ST_CELL_RD;
                    end
                    ACT_ADVANCE:
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = sts.empty ? ST_DONE : ST_ADV_LOAD;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_CELL_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CELL;
                state_next = ST_CELL_UPD;
            end
            ST_CELL_UPD:
            begin
                cmd.wr_en  = (sts.action == ACT_WRITE);
                cmd.wr_sel = WR_CELL;
                state_next = ST_DONE;
            end
            ST_ADV_LOAD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
                state_next = ST_ADV_CUR;
            end
            ST_ADV_CUR:
            begin
                cmd.cur_load = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_NEXT;
                state_next   = ST_ADV_WR;
            end
            ST_ADV_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_NEXT;
                state_next = ST_ADV_WR;
            end
            ST_ADV_WR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = WR_GEN;
                cmd.adv_step = 1'b1;
                cmd.row_inc  = 1'b1;
                state_next   = sts.last_gen ? ST_DONE : ST_ADV_RD;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/lgs_datapath.sv =====
// ----------------------------------------------------------------------------
// lgs_datapath
// Grid memory of one row per word, size registers, request registers, the
// three-row window with its neighbour count and rule, and the result register.
// ----------------------------------------------------------------------------
module lgs_datapath
    import lgs_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  cmd_t                   cmd,
    output sts_t                   sts
);

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);

    logic [CFG_DATA_W-1:0] grid_width_reg;
    logic [CFG_DATA_W-1:0] grid_height_reg;
    logic [RCW-1:0]        act_rows;
    logic [CCW-1:0]        act_cols;

    logic [ACT_W-1:0] item_action_reg;
    logic [POS_W-1:0] item_row_reg;
    logic [POS_W-1:0] item_col_reg;
    logic             item_alive_reg;
    logic [RW-1:0]    cell_row;
    logic [CW-1:0]    cell_col;
    logic             item_oor;

    logic [RW-1:0]       row_cnt_reg;
    logic                has_below;
    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_COLS-1:0] rd_data_reg;
    logic [RW-1:0]       rd_addr;
    logic [RW-1:0]       wr_addr;
    logic [MAX_COLS-1:0] wr_data;
    logic [MAX_COLS-1:0] cell_row_mod;

    logic [MAX_COLS-1:0] above_reg;
    logic [MAX_COLS-1:0] cur_reg;
    logic [MAX_COLS-1:0] col_mask;
    logic [MAX_COLS-1:0] gen_row;
    logic [MAX_COLS+1:0] above_pad;
    logic [MAX_COLS+1:0] cur_pad;
    logic [MAX_COLS+1:0] below_pad;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   res_alive;
    logic                   res_oor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_SIZE_RESET;
            grid_height_reg <= GRID_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    assign act_rows = (int'(grid_height_reg) < MAX_ROWS) ? RCW'(grid_height_reg) : RCW'(MAX_ROWS);
    assign act_cols = (int'(grid_width_reg) < MAX_COLS) ? CCW'(grid_width_reg) : CCW'(MAX_COLS);

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_action_reg <= s_tdata[1:0];
            item_row_reg    <= s_tdata[8:2];
            item_col_reg    <= s_tdata[15:9];
            item_alive_reg  <= s_tdata[16];
        end
    end

    assign cell_row = RW'(item_row_reg);
    assign cell_col = CW'(item_col_reg);
    assign item_oor = (int'(item_row_reg) >= int'(act_rows))
                   || (int'(item_col_reg) >= int'(act_cols));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
        end
        else if (cmd.cnt_clr)
        begin
            row_cnt_reg <= '0;
        end
        else if (cmd.row_inc)
        begin
            row_cnt_reg <= row_cnt_reg + RW'(1);
        end
    end

    assign has_below = (int'(row_cnt_reg) + 1) < int'(act_rows);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_CELL: rd_addr = cell_row;
            RD_CUR:  rd_addr = row_cnt_reg;
            RD_NEXT: rd_addr = row_cnt_reg + RW'(1);
            default: rd_addr = row_cnt_reg;
        endcase
    end

    always_comb
    begin
        cell_row_mod           = rd_data_reg;
        cell_row_mod[cell_col] = item_alive_reg;
    end

    always_comb
    begin
        wr_addr = row_cnt_reg;
        unique case (cmd.wr_sel)
            WR_ZERO: wr_data = '0;
            WR_CELL:
            begin
                wr_addr = cell_row;
                wr_data = cell_row_mod;
            end
            WR_GEN:  wr_data = gen_row;
            default: wr_data = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_mask[c] = (c < int'(act_cols));
        end
    end

    assign above_pad = {1'b0, above_reg, 1'b0};
    assign cur_pad   = {1'b0, cur_reg & col_mask, 1'b0};
    assign below_pad = has_below ? {1'b0, rd_data_reg & col_mask, 1'b0} : '0;

    always_comb
    begin
        logic [3:0] cnt;
        cnt = '0;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            cnt = 4'(above_pad[c]) + 4'(above_pad[c+1]) + 4'(above_pad[c+2])
                + 4'(cur_pad[c]) + 4'(cur_pad[c+2])
                + 4'(below_pad[c]) + 4'(below_pad[c+1]) + 4'(below_pad[c+2]);
            gen_row[c] = col_mask[c] ? ((cnt == 4'd3) || (cur_reg[c] && (cnt == 4'd2)))
                                     : cur_reg[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cur_load)
        begin
            above_reg <= '0;
            cur_reg   <= rd_data_reg;
        end
        else if (cmd.adv_step)
        begin
            above_reg <= cur_reg & col_mask;
            cur_reg   <= rd_data_reg;
        end
    end

    assign res_oor   = ((item_action_reg == ACT_WRITE) || (item_action_reg == ACT_READ))
                    && item_oor;
    assign res_alive = (item_action_reg == ACT_READ) && !item_oor && rd_data_reg[cell_col];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_data_reg <= {4'b0000, res_oor, item_action_reg, res_alive};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign sts.action     = item_action_reg;
    assign sts.oor        = item_oor;
    assign sts.empty      = (act_rows == '0) || (act_cols == '0);
    assign sts.last_clear = (int'(row_cnt_reg) == MAX_ROWS - 1);
    assign sts.last_gen   = !has_below;
    assign sts.out_free   = !out_valid_reg || m_tready;

endmodule

// ===== rtl/life_grid_generation_step.sv =====
// Cell read or write: the result follows a row read and, for a write, a row write;
// refused requests, the unused code and an empty advance go straight to the result.
// Advance: each row takes one memory read and one write.
// The next request is taken in the cycle after the result is issued; that result may wait.
// After reset the grid memory is cleared one row a cycle, all MAX_ROWS rows, before
// the first request is accepted.
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Bit grid of live and dead cells with single-cell access and a B3/S23
// generation step, built as a controller and a row-wide datapath.
// ----------------------------------------------------------------------------
module life_grid_generation_step
    import lgs_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // action[1:0], row[8:2], col[15:9], alive_in[16], zero[23:17]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // alive_out[0], done_action[2:1], out_of_range[3], zero[7:4]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cmd_t cmd;
    sts_t sts;

    lgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lgs_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
